>>> rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Holds the list capacity, derived widths, operation and status codes, the
// payload structs of both channels and the struct for the entry store port.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // Number of entries the list can hold.
  localparam int unsigned Capacity = 8;
  // Width of an entry index and of the entry count.
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  // Width used to compare an insert position against count + 1.
  localparam int unsigned CmpW = ((CntW > 4) ? CntW : 4) + 1;

  typedef logic [IdxW-1:0] pal_idx_t;
  typedef logic [CntW-1:0] pal_cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_CLEAR  = 2'd2
  } pal_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } pal_status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         position;
    logic signed [31:0] value;
  } pal_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_position;
    logic [3:0] list_length;
    logic       empty_res;
  } pal_out_t;

  // Request from the sequencer to the entry store.
  typedef struct packed {
    logic        we;
    pal_idx_t    waddr;
    logic [31:0] wdata;
    pal_idx_t    raddr;
  } pal_store_req_t;

endpackage

`default_nettype wire

>>> rtl/pal_store.sv
// ----------------------------------------------------------------------------
// pal_store: entry store of the positional array list
// A small register file with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_store
  import pal_pkg::*;
(
  input  wire logic           clk_i,
  input  wire pal_store_req_t req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem_q [Capacity];
  logic [31:0] rdata_q;

  // Entries are undefined until written, so the array has no reset. Read data
  // is registered and appears in the cycle after its address.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/pal_seq.sv
// ----------------------------------------------------------------------------
// pal_seq: sequencer of the positional array list
// Steps one entry per cycle through the store, shifting for an insert and
// comparing for a find, and keeps the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_seq
  import pal_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire pal_in_t        item_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  wire logic           res_take_i,
  output pal_out_t            res_o,
  output pal_store_req_t      store_req_o,
  input  wire logic [31:0]    store_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INSERT = 4'b0010,
    S_FIND   = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  pal_cnt_t    count_q, count_d;
  pal_idx_t    idx_q, idx_d;
  pal_idx_t    tgt_q, tgt_d;
  logic [31:0] value_q, value_d;
  pal_status_e status_q, status_d;
  logic [3:0]  found_q, found_d;

  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] limit;
  logic            pos_bad;
  logic            last_entry;

  assign pos_ext    = CmpW'(item_i.position);
  assign limit      = CmpW'(count_q) + CmpW'(1);
  assign pos_bad    = (item_i.position == 4'd0) || (pos_ext > limit);
  assign last_entry = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    value_d  = value_q;
    status_d = status_q;
    found_d  = found_q;

    store_req_o.we    = 1'b0;
    store_req_o.waddr = idx_q;
    store_req_o.wdata = store_rdata_i;
    store_req_o.raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        // The store read port is registered, so the first entry needed is
        // addressed while the item is accepted.
        store_req_o.raddr = (item_i.op == OP_FIND) ? '0 :
                            IdxW'(count_q) - IdxW'(1);
        if (start_i) begin
          value_d  = item_i.value;
          status_d = ST_OK;
          found_d  = 4'd0;
          state_d  = S_DONE;
          case (item_i.op)
            OP_INSERT: begin
              if (pos_bad) begin
                status_d = ST_BAD_POS;
              end else if (count_q >= CntW'(Capacity)) begin
                status_d = ST_FULL;
              end else begin
                idx_d   = IdxW'(count_q);
                tgt_d   = IdxW'(item_i.position - 4'd1);
                state_d = S_INSERT;
              end
            end
            OP_FIND: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                idx_d   = '0;
                state_d = S_FIND;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        store_req_o.we    = 1'b1;
        store_req_o.raddr = idx_q - IdxW'(2);
        if (idx_q != tgt_q) begin
          // Move the entry below up one place.
          idx_d = idx_q - IdxW'(1);
        end else begin
          store_req_o.wdata = value_q;
          count_d = count_q + CntW'(1);
          state_d = S_DONE;
        end
      end
      S_FIND: begin
        store_req_o.raddr = idx_q + IdxW'(1);
        if (store_rdata_i == value_q) begin
          found_d = 4'(CntW'(idx_q) + CntW'(1));
          state_d = S_DONE;
        end else if (last_entry) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    value_q  <= value_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_o.status         = status_q;
  assign res_o.found_position = found_q;
  assign res_o.list_length    = 4'(count_q);
  assign res_o.empty_res      = (count_q == '0);

endmodule

`default_nettype wire

>>> rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: fixed-capacity list of signed 32-bit values
// A clear, an undefined operation, a rejected insert or a find on an empty
// list goes straight to its result item; an insert at position p shifts
// the entries from the end down to p, a find compares from entry 1 up to its
// first match or the last entry. One entry is handled per cycle. The next
// item is accepted only once the previous result item has entered the
// output register. Reset empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list
  import pal_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pal_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output pal_out_t      out_data_o
);

  logic           seq_idle;
  logic           res_valid;
  logic           res_take;
  pal_out_t       res;
  pal_store_req_t store_req;
  logic [31:0]    store_rdata;

  logic     out_valid_q;
  pal_out_t out_data_q;

  // A new item is taken whenever the sequencer is idle, even while the
  // previous result item still waits in the output register.
  assign in_ready_o = seq_idle;

  // The finished result moves into the output register once that is free
  // or is being emptied in this cycle.
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  pal_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i && seq_idle),
    .item_i        (in_data_i),
    .idle_o        (seq_idle),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata)
  );

  pal_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // Output register: holds the result item steady until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> verif/tb_positional_array_list.sv
// ----------------------------------------------------------------------------
// tb_positional_array_list: self-checking testbench of the positional list
// A queue of items, directed first and then random, feeds a clocked driver.
// Each accepted item runs through a shadow copy of the list, and a clocked
// monitor compares every result item field by field with the oldest
// expected one, under three phases of idling on both channels.
// ----------------------------------------------------------------------------
module tb_positional_array_list;
  import pal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The operation field has one code with no operation behind it; the block
  // must leave the list alone and report success.
  localparam logic [1:0] OpUndefined = 2'd3;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned DrainCycles = 20;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  pal_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  pal_out_t out_data_o;

  positional_array_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Items waiting to be driven, and results that accepted items must cause.
  pal_in_t  pending_items[$];
  pal_out_t expected_results[$];
  pal_out_t next_expected;

  int unsigned total_items = 0;
  int unsigned issued_items = 0;
  int unsigned accepted_items = 0;
  int unsigned errors = 0;

  // What the run reached, for the closing summary.
  int unsigned n_inserted = 0;
  int unsigned n_bad_pos = 0;
  int unsigned n_full = 0;
  int unsigned n_found = 0;
  int unsigned n_not_found = 0;
  int unsigned n_cleared = 0;
  int unsigned n_undefined = 0;

  // Shadow copy of the list. Only positions 1 to shadow_count are ever read.
  logic [31:0] shadow_entries [Capacity];
  int unsigned shadow_count = 0;

  // Length of the list as the generator sees it, so that most random
  // inserts can be given a position that the block will accept.
  int unsigned gen_count = 0;

  // Applies one accepted item to the shadow list and returns the result
  // item that the block has to produce for it.
  function automatic pal_out_t list_apply(input pal_in_t item);
    pal_out_t    res;
    int unsigned pos;
    res.status         = ST_OK;
    res.found_position = '0;
    pos = item.position;
    if (item.op == OP_INSERT) begin
      // A bad position is reported even when the list is also full.
      if (pos < 1 || pos > shadow_count + 1) begin
        res.status = ST_BAD_POS;
        n_bad_pos++;
      end else if (shadow_count >= Capacity) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        for (int i = shadow_count; i >= int'(pos); i--) begin
          shadow_entries[i] = shadow_entries[i-1];
        end
        shadow_entries[pos-1] = item.value;
        shadow_count++;
        n_inserted++;
      end
    end else if (item.op == OP_FIND) begin
      res.status = ST_NOT_FOUND;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_entries[i] == item.value) begin
          res.status         = ST_OK;
          res.found_position = 4'(i + 1);
          break;
        end
      end
      if (res.status == ST_OK) n_found++;
      else n_not_found++;
    end else if (item.op == OP_CLEAR) begin
      shadow_count = 0;
      n_cleared++;
    end else begin
      n_undefined++;
    end
    res.list_length = 4'(shadow_count);
    res.empty_res   = (shadow_count == 0);
    return res;
  endfunction

  // Queues one item for the driver and keeps the generator's view of the
  // list length up to date.
  task automatic queue_op(input logic [1:0] op, input int unsigned pos,
                          input logic [31:0] val);
    pal_in_t item;
    item.op       = op;
    item.position = 4'(pos);
    item.value    = val;
    pending_items.push_back(item);
    if (op == OP_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < Capacity) begin
      gen_count++;
    end else if (op == OP_CLEAR) begin
      gen_count = 0;
    end
  endtask

  // The run has three phases by the number of items issued: first the
  // sender idles more lightly than the receiver, then the other way round,
  // and at last neither side idles at all.
  function automatic int unsigned idle_percent(input bit sender_side);
    if (issued_items < total_items / 3) begin
      return sender_side ? 31 : 53;
    end else if (issued_items < 2 * total_items / 3) begin
      return sender_side ? 53 : 31;
    end
    return 0;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Driver. An item that has been offered is held until the block takes it;
  // only then may the next item, or a gap, follow. The shadow list is
  // updated at the very edge at which an item is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(list_apply(in_data));
        accepted_items++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          issued_items++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result item counts when valid and ready are both high at an
  // edge; it is then matched against the oldest expectation. Ready is drawn
  // afresh every cycle according to the current phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected, actual %p", $time, out_data_o);
      end else begin
        next_expected = expected_results.pop_front();
        check_field("status", next_expected.status, out_data_o.status);
        check_field("found_position", next_expected.found_position,
                    out_data_o.found_position);
        check_field("list_length", next_expected.list_length, out_data_o.list_length);
        check_field("empty_res", next_expected.empty_res, out_data_o.empty_res);
      end
    end
    out_ready <= ($urandom_range(99) >= idle_percent(1'b0));
  end

  // Stimulus, reset and the end of the run.
  initial begin
    logic [1:0]  op;
    int unsigned pos;
    int unsigned roll;
    logic [31:0] val;
    logic [31:0] value_pool [6];

    for (int i = 0; i < Capacity; i++) shadow_entries[i] = '0;

    // Directed part: the empty list, rejected positions on both sides of the
    // valid range, inserts at the front, middle and end, the most positive
    // and most negative values, duplicates, a full list, the undefined
    // operation, and a clear that leaves stale entries behind.
    queue_op(OP_FIND, 0, 32'h0000_0000);
    queue_op(OP_INSERT, 0, 32'h0000_0005);
    queue_op(OP_INSERT, 2, 32'h0000_0005);
    queue_op(OP_INSERT, 15, 32'h0000_0005);
    queue_op(OP_INSERT, 1, 32'h7fff_ffff);
    queue_op(OP_INSERT, 1, 32'h8000_0000);
    queue_op(OP_INSERT, 3, 32'hffff_ffff);
    queue_op(OP_INSERT, 2, 32'h0000_0000);
    queue_op(OP_FIND, 0, 32'h8000_0000);
    queue_op(OP_FIND, 15, 32'hffff_ffff);
    queue_op(OP_FIND, 0, 32'h0000_3039);
    queue_op(OpUndefined, 15, $urandom);
    queue_op(OP_INSERT, 5, 32'h7fff_ffff);
    queue_op(OP_INSERT, 1, 32'h0000_0001);
    queue_op(OP_INSERT, 4, 32'h0000_0002);
    queue_op(OP_INSERT, 8, 32'h0000_0003);
    queue_op(OP_INSERT, 9, 32'h0000_0004);
    queue_op(OP_INSERT, 10, 32'h0000_0004);
    queue_op(OP_INSERT, 0, 32'h0000_0004);
    queue_op(OP_FIND, 0, 32'h0000_0003);
    queue_op(OP_FIND, 0, 32'h7fff_ffff);
    queue_op(OP_CLEAR, 0, 32'h0000_0000);
    queue_op(OP_FIND, 0, 32'h0000_0000);
    queue_op(OP_INSERT, 2, 32'h0000_0009);
    queue_op(OP_CLEAR, 7, $urandom);

    // Random part. Most inserts get a position that the list accepts, so the
    // list fills up often; values are drawn mostly from a small pool that is
    // renewed now and then, so that finds hit entries and duplicates.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) begin
        for (int k = 0; k < 6; k++) begin
          case ($urandom_range(7))
            0:       value_pool[k] = 32'h8000_0000;
            1:       value_pool[k] = 32'h7fff_ffff;
            2:       value_pool[k] = 32'hffff_ffff;
            3:       value_pool[k] = 32'h0000_0000;
            default: value_pool[k] = $urandom;
          endcase
        end
      end
      roll = $urandom_range(99);
      pos  = $urandom_range(15);
      if (roll < 52) begin
        op = OP_INSERT;
        if (gen_count < Capacity && $urandom_range(9) < 8) begin
          pos = $urandom_range(gen_count + 1, 1);
        end
      end else if (roll < 88) begin
        op = OP_FIND;
      end else if (roll < 97) begin
        op = OP_CLEAR;
      end else begin
        op = OpUndefined;
      end
      val = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(5)];
      queue_op(op, pos, val);
    end
    total_items = pending_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to be taken and every result to be seen, then let
    // a few more cycles pass so that a stray extra result would show up.
    while (accepted_items < total_items || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d items: %0d inserts, %0d bad positions, %0d on a full list,",
             accepted_items, n_inserted, n_bad_pos, n_full);
    $display("%0d finds with a match, %0d without, %0d clears, %0d undefined operations.",
             n_found, n_not_found, n_cleared, n_undefined);
    if (errors == 0) begin
      $display("positional_array_list test passed");
    end else begin
      $display("positional_array_list test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1ms;
    $display("Timeout with %0d items accepted and %0d results outstanding.",
             accepted_items, expected_results.size());
    $display("positional_array_list test failed");
    $finish;
  end

endmodule

>>> positional_array_list.f
rtl/pal_pkg.sv
rtl/pal_store.sv
rtl/pal_seq.sv
rtl/positional_array_list.sv
verif/tb_positional_array_list.sv
